// ===== src/blps_pkg.sv =====
// Shared types, constants and the sine table for the bitcrush LFO pitch shifter.
// Used by blps_seq, blps_datapath and the top level; depends on nothing else.
package blps_pkg;

    // Ring and pointer geometry
    localparam int RING_DEPTH = 512;
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int FRAC_BITS  = 16;
    localparam int PTR_W      = RING_AW + FRAC_BITS;
    localparam int SAMPLE_W   = 12;
    localparam int SAMPLE_MAX = 4095;

    // LFO and modulation arithmetic
    localparam int PHASE_W     = 32;
    localparam int SINE_AW     = 8;
    localparam int SINE_W      = 8;
    localparam int STEP_W      = 20;
    localparam int MAG_W       = 23;
    localparam int QUOT_W      = 17;
    localparam int SINE_SCALE  = 127;
    localparam int RECIP_SHIFT = 30;
    localparam logic [23:0] RECIP_MUL = 24'((2 ** RECIP_SHIFT) / SINE_SCALE);

    // Configuration register widths and reset values
    localparam int CRUSH_W   = 5;
    localparam int PITCH_W   = 18;
    localparam int DEPTH_W   = 16;
    localparam int LFO_INC_W = 32;
    localparam logic [CRUSH_W-1:0]   CRUSH_RESET   = 5'd1;
    localparam logic [PITCH_W-1:0]   PITCH_RESET   = 18'd65536;
    localparam logic [DEPTH_W-1:0]   DEPTH_RESET   = 16'd0;
    localparam logic [LFO_INC_W-1:0] LFO_INC_RESET = 32'd486948;

    typedef enum logic [1:0] {
        REG_CRUSH   = 2'd0,
        REG_PITCH   = 2'd1,
        REG_DEPTH   = 2'd2,
        REG_LFO_INC = 2'd3
    } reg_idx_t;

    // Microcode
    localparam int UC_STEP_W = 4;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LATCH,
        OP_SINE_WRITE,
        OP_MUL_DEPTH,
        OP_MUL_RECIP,
        OP_CORRECT,
        OP_STEP_SUM,
        OP_PTR_ADV,
        OP_READ0,
        OP_READ1,
        OP_MUL_FRAC,
        OP_EMIT
    } op_t;

    typedef enum logic [1:0] {
        COND_NONE,
        COND_WAIT_IN,
        COND_WAIT_OUT
    } cond_t;

    typedef struct packed {
        op_t                  op;
        cond_t                cond;
        logic                 jump;
        logic [UC_STEP_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        op_t  op;
        logic fire;
    } seq_ctl_t;

    typedef struct packed {
        logic [CRUSH_W-1:0]   crush;
        logic [PITCH_W-1:0]   pitch;
        logic [DEPTH_W-1:0]   depth;
        logic [LFO_INC_W-1:0] lfo_inc;
    } cfg_t;

    // trunc(127*sin(pi/2 * m/64)) for m = 0..64
    localparam logic [6:0] QUARTER_SINE [65] = '{
        7'd0,   7'd3,   7'd6,   7'd9,   7'd12,  7'd15,  7'd18,  7'd21,
        7'd24,  7'd27,  7'd30,  7'd33,  7'd36,  7'd39,  7'd42,  7'd45,
        7'd48,  7'd51,  7'd54,  7'd57,  7'd59,  7'd62,  7'd65,  7'd67,
        7'd70,  7'd73,  7'd75,  7'd78,  7'd80,  7'd82,  7'd85,  7'd87,
        7'd89,  7'd91,  7'd94,  7'd96,  7'd98,  7'd100, 7'd102, 7'd103,
        7'd105, 7'd107, 7'd108, 7'd110, 7'd112, 7'd113, 7'd114, 7'd116,
        7'd117, 7'd118, 7'd119, 7'd120, 7'd121, 7'd122, 7'd123, 7'd123,
        7'd124, 7'd125, 7'd125, 7'd126, 7'd126, 7'd126, 7'd126, 7'd126,
        7'd127
    };

    // Full-cycle sine from the quarter table: mirror odd quadrants, negate the lower half
    function automatic logic signed [SINE_W-1:0] sine_lookup(input logic [SINE_AW-1:0] idx);
        logic [1:0]        quad;
        logic [5:0]        rem;
        logic [6:0]        m;
        logic [SINE_W-1:0] mag;
        quad = idx[SINE_AW-1:SINE_AW-2];
        rem  = idx[5:0];
        m    = quad[0] ? (7'd64 - {1'b0, rem}) : {1'b0, rem};
        mag  = {1'b0, QUARTER_SINE[m]};
        return quad[1] ? $signed(-mag) : $signed(mag);
    endfunction

endpackage

// ===== src/blps_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered read data.
// Generic; no package dependency.
module blps_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 12,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/blps_seq.sv =====
// Microcode sequencer: step counter, program table and wait/jump control.
// Depends on blps_pkg for the control word and op codes.
module blps_seq
    import blps_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     out_busy,
    output logic     in_ready,
    output seq_ctl_t ctl
);

    localparam logic [UC_STEP_W-1:0] STEP_FIRST = '0;

    logic [UC_STEP_W-1:0] step_reg;
    logic [UC_STEP_W-1:0] step_next;
    ucode_t               word;
    logic                 stall;

    // Program: one control word per step
    function automatic ucode_t ucode(input logic [UC_STEP_W-1:0] step);
        ucode_t w;
        w = '{op: OP_NOP, cond: COND_NONE, jump: 1'b0, target: STEP_FIRST};
        unique case (step)
            4'd0:    w.op = OP_LATCH;
            4'd1:    w.op = OP_SINE_WRITE;
            4'd2:    w.op = OP_MUL_DEPTH;
            4'd3:    w.op = OP_MUL_RECIP;
            4'd4:    w.op = OP_CORRECT;
            4'd5:    w.op = OP_STEP_SUM;
            4'd6:    w.op = OP_PTR_ADV;
            4'd7:    w.op = OP_READ0;
            4'd8:    w.op = OP_READ1;
            4'd9:    w.op = OP_MUL_FRAC;
            4'd10:   w.op = OP_EMIT;
            default: w.op = OP_NOP;
        endcase
        if (step == 4'd0)
        begin
            w.cond = COND_WAIT_IN;
        end
        if (step == 4'd10)
        begin
            w.cond = COND_WAIT_OUT;
        end
        if (step >= 4'd10)
        begin
            w.jump = 1'b1;
        end
        return w;
    endfunction

    // Decode the current word and pick the next step
    always_comb
    begin
        word  = ucode(step_reg);
        stall = ((word.cond == COND_WAIT_IN) && !in_valid) ||
                ((word.cond == COND_WAIT_OUT) && out_busy);
        if (stall)
        begin
            step_next = step_reg;
        end
        else if (word.jump)
        begin
            step_next = word.target;
        end
        else
        begin
            step_next = step_reg + 1'b1;
        end
        ctl.op   = word.op;
        ctl.fire = !stall;
        in_ready = (word.cond == COND_WAIT_IN);
    end

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_FIRST;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    // An accepted beat starts the program
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (step_reg == 4'd1))
        else $error("sequencer did not advance after input beat");

    // The emit step holds while the output register is still occupied
    a_emit_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (word.cond == COND_WAIT_OUT && out_busy) |=> $stable(step_reg))
        else $error("sequencer left emit step while output busy");

    // Input is only offered at the start of the program
    a_ready_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (step_reg == STEP_FIRST))
        else $error("input ready outside the first step");

endmodule

// ===== src/blps_datapath.sv =====
// Datapath: bitcrusher, LFO, read-step arithmetic, ring buffer and interpolator.
// Depends on blps_pkg and instantiates blps_ram for the ring.
module blps_datapath
    import blps_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  seq_ctl_t            ctl,
    input  cfg_t                cfg,
    input  logic [SAMPLE_W-1:0] sample_in,
    output logic [SAMPLE_W-1:0] sample_out,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                out_busy
);

    // Control state
    logic [CRUSH_W-1:0]  hold_count_reg, hold_count_next;
    logic [RING_AW-1:0]  wp_reg, wp_next;
    logic                wrapped_reg, wrapped_next;
    logic [PTR_W-1:0]    rp_reg, rp_next;
    logic [PHASE_W-1:0]  phase_reg, phase_next;
    logic                out_valid_reg, out_valid_next;
    logic                rd_ok_reg;

    // Payload
    logic [SAMPLE_W-1:0]      held_reg, held_next;
    logic signed [SINE_W-1:0] sine_reg, sine_next;
    logic                     neg_reg, neg_next;
    logic [MAG_W-1:0]         mag_reg, mag_next;
    logic [QUOT_W-1:0]        qest_reg, qest_next;
    logic [QUOT_W-1:0]        q_reg, q_next;
    logic                     rnz_reg, rnz_next;
    logic signed [STEP_W-1:0] step_reg, step_next;
    logic [SAMPLE_W-1:0]      a_reg, a_next;
    logic signed [29:0]       interp_reg, interp_next;
    logic [SAMPLE_W-1:0]      out_reg, out_next;

    // Combinational helpers
    logic [CRUSH_W:0]         hold_sum;
    logic signed [24:0]       prod_full;
    logic [46:0]              recip_full;
    logic [23:0]              q_times;
    logic [23:0]              rem_raw;
    logic [23:0]              rem_fix;
    logic                     rem_over;
    logic [QUOT_W:0]          mod_mag;
    logic signed [STEP_W-1:0] mod_val;
    logic [SAMPLE_W-1:0]      rd_sample;
    logic signed [12:0]       diff;
    logic signed [13:0]       mix;
    logic [RING_AW-1:0]       idx0;

    // Ring port
    logic                ram_we;
    logic [RING_AW-1:0]  ram_raddr;
    logic [SAMPLE_W-1:0] ram_rdata;

    blps_ram #(
        .DEPTH (RING_DEPTH),
        .WIDTH (SAMPLE_W)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (held_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign idx0      = rp_reg[PTR_W-1:FRAC_BITS];
    assign ram_raddr = (ctl.op == OP_READ1) ? (idx0 + 1'b1) : idx0;
    // Entries never written since reset read as zero
    assign rd_sample = rd_ok_reg ? ram_rdata : '0;

    // Arithmetic feeding each step
    always_comb
    begin
        hold_sum   = {1'b0, hold_count_reg} + 1'b1;
        prod_full  = sine_reg * $signed({1'b0, cfg.depth});
        recip_full = mag_reg * RECIP_MUL;
        q_times    = {qest_reg, 7'b0} - {7'b0, qest_reg};
        rem_raw    = {1'b0, mag_reg} - q_times;
        rem_over   = (rem_raw >= 24'(SINE_SCALE));
        rem_fix    = rem_over ? (rem_raw - 24'(SINE_SCALE)) : rem_raw;
        // round the magnitude up only for a negative product with a remainder
        mod_mag    = {1'b0, q_reg} + {{QUOT_W{1'b0}}, (rnz_reg && neg_reg)};
        mod_val    = neg_reg ? -$signed(STEP_W'(mod_mag)) : $signed(STEP_W'(mod_mag));
        diff       = $signed({1'b0, rd_sample}) - $signed({1'b0, a_reg});
        mix        = $signed({2'b0, a_reg}) + $signed(interp_reg[29:16]);
    end

    // Next-state per microcode op
    always_comb
    begin
        hold_count_next = hold_count_reg;
        held_next       = held_reg;
        wp_next         = wp_reg;
        wrapped_next    = wrapped_reg;
        rp_next         = rp_reg;
        phase_next      = phase_reg;
        sine_next       = sine_reg;
        neg_next        = neg_reg;
        mag_next        = mag_reg;
        qest_next       = qest_reg;
        q_next          = q_reg;
        rnz_next        = rnz_reg;
        step_next       = step_reg;
        a_next          = a_reg;
        interp_next     = interp_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        ram_we          = 1'b0;

        if (ctl.fire)
        begin
            unique case (ctl.op)
                OP_LATCH:
                begin
                    // advance the hold counter, latch on reaching the factor
                    if (hold_sum >= {1'b0, cfg.crush})
                    begin
                        hold_count_next = '0;
                        held_next       = sample_in;
                    end
                    else
                    begin
                        hold_count_next = hold_sum[CRUSH_W-1:0];
                    end
                    phase_next = phase_reg + cfg.lfo_inc;
                end
                OP_SINE_WRITE:
                begin
                    sine_next = sine_lookup(phase_reg[PHASE_W-1:PHASE_W-SINE_AW]);
                    ram_we    = 1'b1;
                    wp_next   = wp_reg + 1'b1;
                    if (wp_reg == RING_AW'(RING_DEPTH - 1))
                    begin
                        wrapped_next = 1'b1;
                    end
                end
                OP_MUL_DEPTH:
                begin
                    neg_next = prod_full[24];
                    mag_next = prod_full[24] ? MAG_W'(-prod_full) : MAG_W'(prod_full);
                end
                OP_MUL_RECIP:
                begin
                    // quotient estimate by reciprocal, at most one short
                    qest_next = recip_full[46:RECIP_SHIFT];
                end
                OP_CORRECT:
                begin
                    q_next   = qest_reg + {{(QUOT_W-1){1'b0}}, rem_over};
                    rnz_next = (rem_fix != '0);
                end
                OP_STEP_SUM:
                begin
                    // floor division: negative values round away from zero
                    step_next = $signed({2'b0, cfg.pitch}) + mod_val;
                end
                OP_PTR_ADV:
                begin
                    // pointer span is a power of two, so wrap is plain truncation
                    rp_next = rp_reg + PTR_W'(step_reg);
                end
                OP_READ0:
                begin
                end
                OP_READ1:
                begin
                    a_next = rd_sample;
                end
                OP_MUL_FRAC:
                begin
                    interp_next = diff * $signed({1'b0, rp_reg[FRAC_BITS-1:0]});
                end
                OP_EMIT:
                begin
                    if (mix < 0)
                    begin
                        out_next = '0;
                    end
                    else if (mix > 14'(SAMPLE_MAX))
                    begin
                        out_next = SAMPLE_W'(SAMPLE_MAX);
                    end
                    else
                    begin
                        out_next = mix[SAMPLE_W-1:0];
                    end
                    out_valid_next = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_count_reg <= '0;
            held_reg       <= '0;
            wp_reg         <= '0;
            wrapped_reg    <= 1'b0;
            rp_reg         <= '0;
            phase_reg      <= '0;
            out_valid_reg  <= 1'b0;
            rd_ok_reg      <= 1'b0;
        end
        else
        begin
            hold_count_reg <= hold_count_next;
            held_reg       <= held_next;
            wp_reg         <= wp_next;
            wrapped_reg    <= wrapped_next;
            rp_reg         <= rp_next;
            phase_reg      <= phase_next;
            out_valid_reg  <= out_valid_next;
            rd_ok_reg      <= wrapped_reg || (ram_raddr < wp_reg);
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        sine_reg   <= sine_next;
        neg_reg    <= neg_next;
        mag_reg    <= mag_next;
        qest_reg   <= qest_next;
        q_reg      <= q_next;
        rnz_reg    <= rnz_next;
        step_reg   <= step_next;
        a_reg      <= a_next;
        interp_reg <= interp_next;
        out_reg    <= out_next;
    end

    assign sample_out = out_reg;
    assign out_valid  = out_valid_reg;
    assign out_busy   = out_valid_reg && !out_ready;

    // Hold counter stays below the largest factor
    a_hold_range: assert property (@(posedge clk) disable iff (!rst_n)
        hold_count_reg != 5'd31)
        else $error("hold counter out of range");

    // Once the ring has been filled it stays filled
    a_wrapped_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        wrapped_reg |=> wrapped_reg)
        else $error("ring fill flag dropped");

    // Corrected quotient never exceeds the modulation depth
    a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.fire && ctl.op == OP_CORRECT) |=> (q_reg <= {1'b0, cfg.depth}))
        else $error("modulation quotient exceeds depth");

endmodule

// ===== src/bitcrush_lfo_pitch_shifter.sv =====
// Bitcrush LFO pitch shifter: top level with APB register file, sequencer and datapath.
// Each input beat runs through the 11-step microprogram on the shared datapath and ring port,
// so a new sample is taken only once the previous one has passed the emit step.
// The next input beat is taken while a finished sample waits on the output.
// Reset clears registers to defaults and pointers, phase and hold state to zero;
// ring entries read as zero until written, tracked by the write pointer and a fill flag.
module bitcrush_lfo_pitch_shifter
    import blps_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // Configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // Input channel
    input  logic [SAMPLE_W-1:0] sample_in,
    input  logic                sample_in_valid,
    output logic                sample_in_ready,
    // Output channel
    output logic [SAMPLE_W-1:0] sample_out,
    output logic                sample_out_valid,
    input  logic                sample_out_ready
);

    logic [CRUSH_W-1:0]   crush_factor_reg, crush_factor_next;
    logic [PITCH_W-1:0]   pitch_rate_reg, pitch_rate_next;
    logic [DEPTH_W-1:0]   fm_depth_reg, fm_depth_next;
    logic [LFO_INC_W-1:0] lfo_increment_reg, lfo_increment_next;
    logic                 cfg_write;
    reg_idx_t             reg_sel;
    cfg_t                 cfg;
    seq_ctl_t             ctl;
    logic                 out_busy;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_sel   = reg_idx_t'(paddr[3:2]);

    // Register writes
    always_comb
    begin
        crush_factor_next  = crush_factor_reg;
        pitch_rate_next    = pitch_rate_reg;
        fm_depth_next      = fm_depth_reg;
        lfo_increment_next = lfo_increment_reg;
        if (cfg_write)
        begin
            unique case (reg_sel)
                REG_CRUSH:   crush_factor_next  = pwdata[CRUSH_W-1:0];
                REG_PITCH:   pitch_rate_next    = pwdata[PITCH_W-1:0];
                REG_DEPTH:   fm_depth_next      = pwdata[DEPTH_W-1:0];
                REG_LFO_INC: lfo_increment_next = pwdata[LFO_INC_W-1:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crush_factor_reg  <= CRUSH_RESET;
            pitch_rate_reg    <= PITCH_RESET;
            fm_depth_reg      <= DEPTH_RESET;
            lfo_increment_reg <= LFO_INC_RESET;
        end
        else
        begin
            crush_factor_reg  <= crush_factor_next;
            pitch_rate_reg    <= pitch_rate_next;
            fm_depth_reg      <= fm_depth_next;
            lfo_increment_reg <= lfo_increment_next;
        end
    end

    // Register reads
    always_comb
    begin
        unique case (reg_sel)
            REG_CRUSH:   prdata = {{(32-CRUSH_W){1'b0}}, crush_factor_reg};
            REG_PITCH:   prdata = {{(32-PITCH_W){1'b0}}, pitch_rate_reg};
            REG_DEPTH:   prdata = {{(32-DEPTH_W){1'b0}}, fm_depth_reg};
            REG_LFO_INC: prdata = lfo_increment_reg;
            default:     prdata = '0;
        endcase
    end

    assign cfg = '{
        crush:   crush_factor_reg,
        pitch:   pitch_rate_reg,
        depth:   fm_depth_reg,
        lfo_inc: lfo_increment_reg
    };

    blps_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample_in_valid),
        .out_busy (out_busy),
        .in_ready (sample_in_ready),
        .ctl      (ctl)
    );

    blps_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .cfg        (cfg),
        .sample_in  (sample_in),
        .sample_out (sample_out),
        .out_valid  (sample_out_valid),
        .out_ready  (sample_out_ready),
        .out_busy   (out_busy)
    );

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for bitcrush_lfo_pitch_shifter.
// Drives sample beats and APB register writes and predicts each output sample in SV.
// Depends on blps_pkg and the bitcrush_lfo_pitch_shifter RTL only.
`timescale 1ns / 100ps

module tb_top;
    import blps_pkg::*;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [3:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic [SAMPLE_W-1:0] sample_in = '0;
    logic                sample_in_valid = 1'b0;
    logic                sample_in_ready;
    logic [SAMPLE_W-1:0] sample_out;
    logic                sample_out_valid;
    logic                sample_out_ready = 1'b0;

    bitcrush_lfo_pitch_shifter i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .sample_in        (sample_in),
        .sample_in_valid  (sample_in_valid),
        .sample_in_ready  (sample_in_ready),
        .sample_out       (sample_out),
        .sample_out_valid (sample_out_valid),
        .sample_out_ready (sample_out_ready)
    );

    // Register copies as the block should hold them
    logic [CRUSH_W-1:0]   crush_q   = CRUSH_RESET;
    logic [PITCH_W-1:0]   pitch_q   = PITCH_RESET;
    logic [DEPTH_W-1:0]   depth_q   = DEPTH_RESET;
    logic [LFO_INC_W-1:0] lfo_inc_q = LFO_INC_RESET;

    // Shifter state mirror
    int unsigned           hold_cnt = 0;
    logic [SAMPLE_W-1:0]   held_sample = '0;
    logic [SAMPLE_W-1:0]   ring_copy [RING_DEPTH];
    logic [RING_AW-1:0]    wr_ptr = '0;
    logic [PTR_W-1:0]      rd_ptr = '0;
    logic [PHASE_W-1:0]    lfo_phase = '0;
    logic signed [7:0]     sine_tab [256];

    logic [SAMPLE_W-1:0] sample_feed [$];
    logic [SAMPLE_W-1:0] shifted_expect [$];
    int                  mismatch_count = 0;

    // Sender burst shaping and receiver stall pattern
    int burst_left = 0;
    int gap_left   = 0;
    int open_left  = 0;
    int stall_left = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    // trunc(127*sin(pi/2 * m/256)) by fixed-point Taylor series in Q30
    function automatic int quarter_sine(input int unsigned m);
        longint unsigned x, x2, term, acc, div;
        int n;
        if (m == 0)
            return 0;
        if (m >= 256)
            return 127;
        x = 64'd1686629713 * m / 64'd256;
        x2 = (x * x) >> 30;
        term = x;
        acc = x;
        for (n = 1; n <= 8; n++) begin
            div = (2 * n) * (2 * n + 1);
            term = ((term * x2) >> 30) / div;
            if (n % 2 == 1)
                acc = acc - term;
            else
                acc = acc + term;
        end
        acc = (acc * 64'd127) >> 30;
        if (acc > 127)
            acc = 127;
        return int'(acc);
    endfunction

    // Fill the full-cycle sine table and clear the ring mirror
    task automatic build_tables();
        int i, quad, rem, m, v;
        for (i = 0; i < 256; i++) begin
            quad = (4 * i) / 256;
            rem  = (4 * i) % 256;
            m    = (quad % 2 == 1) ? (256 - rem) : rem;
            v    = quarter_sine(m);
            if (quad >= 2)
                v = -v;
            sine_tab[i] = 8'(v);
        end
        for (i = 0; i < RING_DEPTH; i++)
            ring_copy[i] = '0;
    endtask

    // Advance the mirror by one input sample and return the output it yields
    function automatic logic [SAMPLE_W-1:0] pitch_shift_next(input logic [SAMPLE_W-1:0] s);
        logic [7:0]         sidx;
        logic [RING_AW-1:0] idx0, idx1;
        longint             prod, fm_offset, rate_step, frac, acc;
        hold_cnt++;
        if (hold_cnt >= crush_q) begin
            hold_cnt = 0;
            held_sample = s;
        end
        lfo_phase = lfo_phase + lfo_inc_q;
        sidx = lfo_phase[31:24];
        prod = longint'(sine_tab[sidx]) * longint'(depth_q);
        // floor division, also for negative products
        if (prod >= 0)
            fm_offset = prod / SINE_SCALE;
        else
            fm_offset = -((-prod + SINE_SCALE - 1) / SINE_SCALE);
        rate_step = longint'(pitch_q) + fm_offset;
        ring_copy[wr_ptr] = held_sample;
        wr_ptr = wr_ptr + 1'b1;
        // pointer wraps both ways modulo the ring span
        rd_ptr = rd_ptr + rate_step[PTR_W-1:0];
        idx0 = rd_ptr[PTR_W-1:FRAC_BITS];
        idx1 = idx0 + 1'b1;
        frac = longint'(rd_ptr[FRAC_BITS-1:0]);
        acc = longint'(ring_copy[idx0]) * (65536 - frac) + longint'(ring_copy[idx1]) * frac;
        acc = acc >>> FRAC_BITS;
        if (acc < 0)
            acc = 0;
        if (acc > SAMPLE_MAX)
            acc = SAMPLE_MAX;
        return acc[SAMPLE_W-1:0];
    endfunction

    // Sender: predict on each accepted beat, then present the next pending sample
    always @(posedge clk) begin
        if (!rst_n) begin
            sample_in_valid <= 1'b0;
        end
        else begin
            if (sample_in_valid && sample_in_ready)
                shifted_expect.push_back(pitch_shift_next(sample_in));
            if (!sample_in_valid || sample_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    sample_in_valid <= 1'b0;
                end
                else if (sample_feed.size() > 0) begin
                    sample_in_valid <= 1'b1;
                    sample_in <= sample_feed.pop_front();
                    if (burst_left > 0) begin
                        burst_left--;
                    end
                    else begin
                        burst_left = $urandom_range(0, 30);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else begin
                    sample_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each accepted output beat, then apply the stall pattern
    always @(posedge clk) begin
        logic [SAMPLE_W-1:0] want;
        if (!rst_n) begin
            sample_out_ready <= 1'b0;
        end
        else begin
            if (sample_out_valid && sample_out_ready) begin
                if (shifted_expect.size() == 0) begin
                    $error("sample_out: expected none, got %0d", sample_out);
                    mismatch_count++;
                end
                else begin
                    want = shifted_expect.pop_front();
                    if (sample_out !== want) begin
                        $error("sample_out: expected %0d, got %0d", want, sample_out);
                        mismatch_count++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                sample_out_ready <= 1'b0;
            end
            else if (open_left > 0) begin
                open_left--;
                sample_out_ready <= 1'b1;
            end
            else begin
                open_left = $urandom_range(0, 40);
                stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                sample_out_ready <= (stall_left == 0);
            end
        end
    end

    // APB write: setup cycle, then access cycle; the register lands on the access edge
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CRUSH:   crush_q   = val[CRUSH_W-1:0];
            REG_PITCH:   pitch_q   = val[PITCH_W-1:0];
            REG_DEPTH:   depth_q   = val[DEPTH_W-1:0];
            REG_LFO_INC: lfo_inc_q = val[LFO_INC_W-1:0];
            default: ;
        endcase
    endtask

    // Hold until every queued sample is sent and every output has come back
    task automatic drain();
        while (sample_feed.size() != 0 || sample_in_valid || shifted_expect.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic load_settings(input logic [31:0] crush, input logic [31:0] pitch,
                                 input logic [31:0] depth, input logic [31:0] lfo_inc);
        drain();
        write_reg(REG_CRUSH, crush);
        write_reg(REG_PITCH, pitch);
        write_reg(REG_DEPTH, depth);
        write_reg(REG_LFO_INC, lfo_inc);
    endtask

    task automatic queue_random(input int count);
        int k;
        for (k = 0; k < count; k++) begin
            if ($urandom_range(0, 7) == 0)
                sample_feed.push_back($urandom_range(0, 1) ? 12'd4095 : 12'd0);
            else
                sample_feed.push_back(12'($urandom));
        end
    endtask

    // Stimulus: directed phases, then random settings and random audio
    initial begin
        int ph;
        logic [31:0] c, p, d, l;
        build_tables();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: field extremes and alternating bit patterns
        sample_feed.push_back(12'd0);
        sample_feed.push_back(12'd4095);
        sample_feed.push_back(12'hAAA);
        sample_feed.push_back(12'h555);
        sample_feed.push_back(12'd4095);
        sample_feed.push_back(12'd0);

        // zero crush factor, zero pitch, full depth: step goes negative on the lower half
        load_settings(32'd0, 32'd0, 32'd65535, 32'h2000_0000);
        repeat (3) begin
            sample_feed.push_back(12'd4095);
            sample_feed.push_back(12'd0);
        end

        // pitch above 2.0, nominal max depth, crush factor of 20, max LFO step
        load_settings(32'd20, 32'd262143, 32'd52429, 32'hFFFF_FFFF);
        repeat (3) begin
            sample_feed.push_back(12'd1);
            sample_feed.push_back(12'd2048);
        end

        // crush factor lowered below the running count: the next sample latches
        load_settings(32'd2, 32'd131072, 32'd0, 32'd0);
        sample_feed.push_back(12'd4094);
        sample_feed.push_back(12'd3);
        sample_feed.push_back(12'd1234);
        sample_feed.push_back(12'd4095);

        // random settings with extremes mixed in
        for (ph = 0; ph < 11; ph++) begin
            case ($urandom_range(0, 4))
                0: c = 0;
                1: c = 31;
                2: c = 1;
                default: c = $urandom_range(1, 20);
            endcase
            case ($urandom_range(0, 5))
                0: p = 0;
                1: p = 65536;
                2: p = 131072;
                3: p = 262143;
                default: p = $urandom_range(0, 262143);
            endcase
            case ($urandom_range(0, 4))
                0: d = 0;
                1: d = 52429;
                2: d = 65535;
                default: d = $urandom_range(0, 65535);
            endcase
            case ($urandom_range(0, 4))
                0: l = 0;
                1: l = 32'hFFFF_FFFF;
                2: l = $urandom_range(1, 2000000);
                default: l = $urandom;
            endcase
            load_settings(c, p, d, l);
            queue_random(50);
        end

        drain();
        repeat (20) @(posedge clk);
        if (shifted_expect.size() != 0) begin
            $error("sample_out: %0d expected outputs never arrived", shifted_expect.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog
    initial begin
        #3000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
